// ===== sv/ip2t_pkg.sv =====
// Shared types, constants and helpers for the indexed pixel to tiled RGB565 block.
// Used by ip2t_ctrl, ip2t_dp, the top level and the checker; depends on nothing.
`default_nettype none

package ip2t_pkg;

  localparam int IDX_W       = 8;
  localparam int COMP_W      = 6;
  localparam int COLOR_W     = 16;
  localparam int OFFSET_W    = 18;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int TEXEL_IDX_W = 4;
  localparam int PAL_DEPTH   = 256;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd224;

  localparam logic [TEXEL_IDX_W-1:0] TEXEL_LAST = 4'hF;

  // input operation codes
  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic pix_accept;
    logic pal_accept;
    logic issue;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tile_done;
    logic last_issue;
    logic advance;
    logic pipe_empty;
  } dp_status_t;

  // 6-bit components to RGB565: drop the low bit of red and blue
  function automatic logic [COLOR_W-1:0] rgb565(input logic [COMP_W-1:0] r,
                                                input logic [COMP_W-1:0] g,
                                                input logic [COMP_W-1:0] b);
    return {r[COMP_W-1:1], g, b[COMP_W-1:1]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/ip2t_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while rd_en is low. No package dependency.
`default_nettype none

module ip2t_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ip2t_ctrl.sv =====
// Sequencer for the tiler: accepts items, steps through the sixteen texel reads, drains.
// Depends on ip2t_pkg.
`default_nettype none

module ip2t_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  wire                     op,
  input  ip2t_pkg::dp_status_t    status,
  output logic                    in_stall,
  output ip2t_pkg::ctrl_cmd_t     cmd
);

  ip2t_pkg::state_t state;
  ip2t_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ip2t_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ip2t_pkg::ST_IDLE: begin
        if (in_valid && (op == ip2t_pkg::OP_PIXEL) && status.tile_done) begin
          state_next = ip2t_pkg::ST_ISSUE;
        end
      end
      ip2t_pkg::ST_ISSUE: begin
        if (status.advance && status.last_issue) begin
          state_next = ip2t_pkg::ST_DRAIN;
        end
      end
      ip2t_pkg::ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = ip2t_pkg::ST_IDLE;
        end
      end
      default: state_next = ip2t_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    cmd.pix_accept = 1'b0;
    cmd.pal_accept = 1'b0;
    cmd.issue      = 1'b0;
    unique case (state)
      ip2t_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.pix_accept = in_valid && (op == ip2t_pkg::OP_PIXEL);
        cmd.pal_accept = in_valid && (op == ip2t_pkg::OP_PALETTE);
      end
      ip2t_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      ip2t_pkg::ST_DRAIN: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ip2t_dp.sv =====
// Datapath: size registers, raster counters, line store, palette and texel pipeline.
// Depends on ip2t_pkg and ip2t_ram.
`default_nettype none

module ip2t_dp #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  ip2t_pkg::ctrl_cmd_t                 cmd,
  output ip2t_pkg::dp_status_t                status,
  input  wire [ip2t_pkg::IDX_W-1:0]           pixel_index,
  input  wire [ip2t_pkg::COMP_W-1:0]          red,
  input  wire [ip2t_pkg::COMP_W-1:0]          green,
  input  wire [ip2t_pkg::COMP_W-1:0]          blue,
  input  wire                                 cfg_write,
  input  wire [ip2t_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ip2t_pkg::CFG_W-1:0]           cfg_data,
  input  wire                                 out_stall,
  output logic                                out_valid,
  output logic [ip2t_pkg::COLOR_W-1:0]        texel_color,
  output logic [ip2t_pkg::OFFSET_W-1:0]       texel_offset,
  output logic                                tile_end,
  output logic                                frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int AW  = $clog2(4 * MAX_WIDTH);
  localparam int WSZ = $clog2(MAX_WIDTH + 1);
  localparam int HSZ = $clog2(MAX_HEIGHT + 1);
  localparam int SZ0 = (WSZ > HSZ) ? WSZ : HSZ;
  localparam int SZW = (SZ0 > ip2t_pkg::CFG_W) ? SZ0 : ip2t_pkg::CFG_W;
  localparam logic [SZW-1:0] W_TOP = SZW'((MAX_WIDTH / 4) * 4);
  localparam logic [SZW-1:0] H_TOP = SZW'((MAX_HEIGHT / 4) * 4);
  localparam logic [SZW-1:0] SZ_MIN = SZW'(4);
  localparam logic [AW-1:0] LINE_PITCH = AW'(MAX_WIDTH);

  logic [ip2t_pkg::CFG_W-1:0] frame_width;
  logic [ip2t_pkg::CFG_W-1:0] frame_height;
  logic [SZW-1:0] w_raw, h_raw, eff_w, eff_h;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          line_wrap, frame_wrap, tile_done;

  logic [CW-3:0]                      tile_col;
  logic                               tile_frame_wrap;
  logic [ip2t_pkg::TEXEL_IDX_W-1:0]   texel_idx;
  logic [ip2t_pkg::OFFSET_W-1:0]      texel_count;
  logic                               advance, issue_fire, last_issue;

  logic [AW-1:0] store_wr_addr, store_rd_addr;
  logic [ip2t_pkg::IDX_W-1:0] store_rd_data;
  logic [ip2t_pkg::COLOR_W-1:0] pal_rd_data;

  logic [ip2t_pkg::PAL_DEPTH-1:0] pal_vld;
  logic                           pal_vld_q;

  logic                            s1_valid, s1_last, s1_frame_end;
  logic [ip2t_pkg::OFFSET_W-1:0]   s1_offset;
  logic                            s2_valid, s2_last, s2_frame_end;
  logic [ip2t_pkg::OFFSET_W-1:0]   s2_offset;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ip2t_pkg::WIDTH_RESET;
      frame_height <= ip2t_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ip2t_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        ip2t_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: drop the low two bits, clamp to [4, max]
  always_comb begin
    w_raw = SZW'({frame_width[ip2t_pkg::CFG_W-1:2], 2'b00});
    h_raw = SZW'({frame_height[ip2t_pkg::CFG_W-1:2], 2'b00});
    eff_w = (w_raw < SZ_MIN) ? SZ_MIN : ((w_raw > W_TOP) ? W_TOP : w_raw);
    eff_h = (h_raw < SZ_MIN) ? SZ_MIN : ((h_raw > H_TOP) ? H_TOP : h_raw);
  end

  assign line_wrap  = (SZW'(col) + SZW'(1)) >= eff_w;
  assign frame_wrap = line_wrap && ((SZW'(row) + SZW'(1)) >= eff_h);
  assign tile_done  = (col[1:0] == 2'b11) && (row[1:0] == 2'b11);

  assign advance    = !out_valid || !out_stall;
  assign issue_fire = cmd.issue && advance;
  assign last_issue = (texel_idx == ip2t_pkg::TEXEL_LAST);

  assign status.tile_done  = tile_done;
  assign status.last_issue = last_issue;
  assign status.advance    = advance;
  assign status.pipe_empty = !s1_valid && !s2_valid;

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.pix_accept) begin
      if (line_wrap) begin
        col <= '0;
        row <= frame_wrap ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // tile context and texel sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_idx   <= '0;
      texel_count <= '0;
    end else if (cmd.pix_accept) begin
      texel_idx <= '0;
      if (frame_wrap && !tile_done) begin
        texel_count <= '0;
      end
    end else if (issue_fire) begin
      texel_idx   <= texel_idx + ip2t_pkg::TEXEL_IDX_W'(1);
      texel_count <= (last_issue && tile_frame_wrap) ? '0
                                                     : texel_count + ip2t_pkg::OFFSET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_accept) begin
      tile_col        <= col[CW-1:2];
      tile_frame_wrap <= frame_wrap;
    end
  end

  // line store: four lines of MAX_WIDTH entries
  assign store_wr_addr = AW'(row[1:0]) * LINE_PITCH + AW'(col);
  assign store_rd_addr = AW'(texel_idx[3:2]) * LINE_PITCH + AW'({tile_col, texel_idx[1:0]});

  ip2t_ram #(
    .WIDTH (ip2t_pkg::IDX_W),
    .DEPTH (4 * MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.pix_accept),
    .wr_addr (store_wr_addr),
    .wr_data (pixel_index),
    .rd_en   (advance),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  ip2t_ram #(
    .WIDTH (ip2t_pkg::COLOR_W),
    .DEPTH (ip2t_pkg::PAL_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (cmd.pal_accept),
    .wr_addr (pixel_index),
    .wr_data (ip2t_pkg::rgb565(red, green, blue)),
    .rd_en   (advance),
    .rd_addr (store_rd_data),
    .rd_data (pal_rd_data)
  );

  // palette entries never written read as black
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if (cmd.pal_accept) begin
      pal_vld[pixel_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pal_vld_q <= pal_vld[store_rd_data];
    end
  end

  // texel pipeline: store read, palette read, output register; all advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue_fire;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last      <= last_issue;
      s1_frame_end <= last_issue && tile_frame_wrap;
      s1_offset    <= texel_count;
      s2_last      <= s1_last;
      s2_frame_end <= s1_frame_end;
      s2_offset    <= s1_offset;
      tile_end     <= s2_last;
      frame_end    <= s2_frame_end;
      texel_offset <= s2_offset;
      texel_color  <= pal_vld_q ? pal_rd_data : '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/indexed_pixel_to_tiled_rgb565_top.sv =====
// Top level of the indexed pixel to tiled RGB565 converter.
// Depends on ip2t_pkg, ip2t_ctrl, ip2t_dp and ip2t_ram.
//
// Input channel (in_valid / in_stall): a raster pixel (op = 0, palette index in
//   pixel_index) or a palette write (op = 1, entry in pixel_index, 6-bit red/green/blue).
// Output channel (out_valid / out_stall): texels with RGB565 colour, offset in the
//   tiled texture, and tile_end / frame_end flags.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): frame_width at
//   index 0, frame_height at index 1; cfg_ready is always high. Write sizes only while
//   the block is idle.
// Throughput: a palette write or a pixel that completes no tile never blocks the
//   input. A pixel that completes a 4x4 tile blocks it while the sixteen line-store
//   reads issue, one a cycle while the output is not stalled, and until the last read
//   has passed the store and palette stages into the output register. Texels leave at
//   one per cycle while the receiver keeps out_stall low.
// A tile's first texel passes the ISSUE state, store read, palette read and output register.
// Stall: while out_stall is high and out_valid is set, the texel pipeline and both RAM
//   read ports hold; the texel on the outputs stays unchanged until transferred.
// Reset: rst (synchronous) clears the counters, sets the sizes to 256 x 224 and clears
//   the palette valid bits so every entry reads black. No clearing pass is needed.
`default_nettype none

module indexed_pixel_to_tiled_rgb565_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 op,
  input  wire [ip2t_pkg::IDX_W-1:0]           pixel_index,
  input  wire [ip2t_pkg::COMP_W-1:0]          red,
  input  wire [ip2t_pkg::COMP_W-1:0]          green,
  input  wire [ip2t_pkg::COMP_W-1:0]          blue,
  // output channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [ip2t_pkg::COLOR_W-1:0]        texel_color,
  output logic [ip2t_pkg::OFFSET_W-1:0]       texel_offset,
  output logic                                tile_end,
  output logic                                frame_end,
  // configuration channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [ip2t_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ip2t_pkg::CFG_W-1:0]           cfg_data
);

  ip2t_pkg::ctrl_cmd_t  cmd;
  ip2t_pkg::dp_status_t status;

  // size registers take a write on any cycle
  assign cfg_ready = 1'b1;

  ip2t_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ip2t_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pixel_index  (pixel_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .texel_color  (texel_color),
    .texel_offset (texel_offset),
    .tile_end     (tile_end),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

// ===== sv/ip2t_checker.sv =====
// Port-level checks for the tiler, bound onto the top level.
// Depends on ip2t_pkg for field widths.
`default_nettype none

module ip2t_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [ip2t_pkg::COLOR_W-1:0]      texel_color,
  input wire [ip2t_pkg::OFFSET_W-1:0]     texel_offset,
  input wire                              tile_end,
  input wire                              frame_end
);

  // hold a stalled texel
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(texel_color) && $stable(texel_offset)
      && $stable(tile_end) && $stable(frame_end))
    else $error("stalled texel changed");

  a_frame_in_tile: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> tile_end)
    else $error("frame end without tile end");

  // tiles are sixteen texels aligned in the offset space
  a_tile_align: assert property (@(posedge clk) disable iff (rst)
    out_valid && tile_end |-> texel_offset[3:0] == 4'hF)
    else $error("tile end at misaligned offset");

  // a tile's texels leave without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !tile_end |=> out_valid)
    else $error("gap inside a tile burst");

  a_reset: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind indexed_pixel_to_tiled_rgb565_top ip2t_checker u_ip2t_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .texel_color  (texel_color),
  .texel_offset (texel_offset),
  .tile_end     (tile_end),
  .frame_end    (frame_end)
);

`default_nettype wire
